// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/mtac_pkg.sv
// Types, constants and the fixed starting state of the twister keystream cipher.
package mtac_pkg;

    localparam int unsigned WORDS   = 624;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned SHIFT_M = 397;
    localparam int unsigned KEY_LEN = 9;
    localparam int unsigned SEED_P  = (WORDS - 11) / 2;
    localparam int unsigned SEED_Q  = SEED_P + 11;

    typedef logic [IDX_W-1:0] mtac_idx_t;
    typedef logic [31:0]      mtac_word_t;
    typedef mtac_word_t       mtac_rom_t [WORDS];

    localparam mtac_idx_t  LAST_IDX    = mtac_idx_t'(WORDS - 1);
    localparam mtac_idx_t  FULL_FILL   = mtac_idx_t'(WORDS);
    localparam mtac_word_t TWIST_CONST = 32'h9908b0df;
    localparam mtac_word_t TEMPER_B    = 32'h9d2c5680;
    localparam mtac_word_t TEMPER_C    = 32'hefc60000;
    localparam mtac_word_t SEED_FILL   = 32'h8b8b8b8b;
    localparam mtac_word_t SEED_MUL_A  = 32'd1664525;
    localparam mtac_word_t SEED_MUL_B  = 32'd1566083941;
    localparam mtac_word_t UPPER_BIT   = 32'h80000000;

    // Fixed key characters, ASCII.
    localparam logic [7:0] KEY_CHARS [KEY_LEN] =
        '{8'h54, 8'h75, 8'h6e, 8'h64, 8'h72, 8'h61, 8'h55, 8'h58, 8'h32};

    typedef struct packed {
        logic [7:0] data_in;
        logic       mode;
        logic       first_of_message;
        logic       last_of_message;
    } mtac_in_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } mtac_out_t;

    function automatic mtac_word_t mix27(input mtac_word_t x);
        return x ^ (x >> 27);
    endfunction

    // Seed-sequence expansion of the key, then the generator's zero-state guard.
    function automatic mtac_rom_t build_start_rom();
        mtac_rom_t  b;
        mtac_word_t r1;
        mtac_word_t r2;
        logic       all_zero;
        for (int i = 0; i < WORDS; i++)
        begin
            b[i] = SEED_FILL;
        end
        for (int k = 0; k < WORDS; k++)
        begin
            r1 = SEED_MUL_A * mix27(b[k] ^ b[(k + SEED_P) % WORDS]
                                    ^ b[(k + WORDS - 1) % WORDS]);
            if (k == 0)
            begin
                r2 = r1 + mtac_word_t'(KEY_LEN);
            end
            else if (k <= KEY_LEN)
            begin
                r2 = r1 + mtac_word_t'(k) + {24'd0, KEY_CHARS[k-1]};
            end
            else
            begin
                r2 = r1 + mtac_word_t'(k);
            end
            b[(k + SEED_P) % WORDS] = b[(k + SEED_P) % WORDS] + r1;
            b[(k + SEED_Q) % WORDS] = b[(k + SEED_Q) % WORDS] + r2;
            b[k] = r2;
        end
        for (int k = WORDS; k < 2 * WORDS; k++)
        begin
            r1 = SEED_MUL_B * mix27(b[k % WORDS] + b[(k + SEED_P) % WORDS]
                                    + b[(k + WORDS - 1) % WORDS]);
            r2 = r1 - mtac_word_t'(k % WORDS);
            b[(k + SEED_P) % WORDS] = b[(k + SEED_P) % WORDS] ^ r1;
            b[(k + SEED_Q) % WORDS] = b[(k + SEED_Q) % WORDS] ^ r2;
            b[k % WORDS] = r2;
        end
        all_zero = ((b[0] & UPPER_BIT) == 32'd0);
        for (int i = 1; i < WORDS; i++)
        begin
            if (b[i] != 32'd0)
            begin
                all_zero = 1'b0;
            end
        end
        if (all_zero)
        begin
            b[0] = UPPER_BIT;
        end
        return b;
    endfunction

    localparam mtac_rom_t START_ROM = build_start_rom();

    function automatic mtac_word_t temper(input mtac_word_t x);
        mtac_word_t t;
        t = x ^ (x >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

// File: rtl/mtac_ram.sv
// Generic RAM: one write port, two registered read ports.
module mtac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// File: rtl/mtac_start_rom.sv
// Starting-state ROM of the twister, two registered read ports.
module mtac_start_rom (
    input  logic                   clk,
    input  logic                   rd_en,
    input  mtac_pkg::mtac_idx_t    addr_a,
    input  mtac_pkg::mtac_idx_t    addr_b,
    output mtac_pkg::mtac_word_t   data_a,
    output mtac_pkg::mtac_word_t   data_b
);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a <= mtac_pkg::START_ROM[addr_a];
            data_b <= mtac_pkg::START_ROM[addr_b];
        end
    end

endmodule

// File: rtl/mt19937_additive_stream_cipher_unit.sv
// Top level of the twister keystream byte cipher.
// One byte per clock when neither side stalls; an accepted byte passes through the twist
// stage registers into the output register. Each byte reads two twister words (the
// neighbor word and the word 397 ahead) through the two read ports of the state RAM
// and the starting-state ROM, and writes one twisted word back as it leaves the twist
// stage; that single read-modify-write pass per byte sets the rate. A byte with
// first_of_message set restarts the generator at once: a fill count tells rewritten
// words from starting words, so there is no clearing pass after reset or restart.
`include "assert_macros.svh"

module mt19937_additive_stream_cipher_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  mtac_pkg::mtac_in_t  src_item,
    output logic                dst_valid,
    input  logic                dst_stall,
    output mtac_pkg::mtac_out_t dst_item
);

    logic                 accept;
    logic                 s1_move;
    mtac_pkg::mtac_idx_t  cur_idx;
    mtac_pkg::mtac_idx_t  cur_fill;
    mtac_pkg::mtac_idx_t  addr_near;
    mtac_pkg::mtac_idx_t  addr_far;
    logic [mtac_pkg::IDX_W:0] far_sum;

    mtac_pkg::mtac_idx_t  index_reg, index_next;
    mtac_pkg::mtac_idx_t  fill_reg, fill_next;
    logic                 s1_valid_reg, s1_valid_next;
    mtac_pkg::mtac_idx_t  s1_idx_reg;
    mtac_pkg::mtac_in_t   s1_item_reg;
    logic                 s1_near_ram_reg;
    logic                 s1_far_ram_reg;
    logic                 s1_fresh_reg;
    logic                 upper_reg;
    logic                 dst_valid_reg, dst_valid_next;
    mtac_pkg::mtac_out_t  dst_item_reg;

    mtac_pkg::mtac_word_t ram_near, ram_far, rom_near, rom_far;
    mtac_pkg::mtac_word_t near_word, far_word, y_word, twisted, tempered;
    logic                 upper_bit;
    logic [7:0]           key_byte;
    logic [7:0]           result_byte;

    assign accept    = src_valid && !src_stall;
    assign s1_move   = s1_valid_reg && (!dst_valid_reg || !dst_stall);
    assign src_stall = s1_valid_reg && !s1_move;

    // Restart takes effect before this byte's reads.
    assign cur_idx   = src_item.first_of_message ? '0 : index_reg;
    assign cur_fill  = src_item.first_of_message ? '0 : fill_reg;
    assign addr_near = (cur_idx == mtac_pkg::LAST_IDX) ? '0 : cur_idx + 1'b1;
    assign far_sum   = {1'b0, cur_idx} + (mtac_pkg::IDX_W + 1)'(mtac_pkg::SHIFT_M);
    assign addr_far  = (far_sum >= (mtac_pkg::IDX_W + 1)'(mtac_pkg::WORDS))
                     ? mtac_pkg::mtac_idx_t'(far_sum - (mtac_pkg::IDX_W + 1)'(mtac_pkg::WORDS))
                     : mtac_pkg::mtac_idx_t'(far_sum);

    mtac_ram #(
        .WIDTH (32),
        .DEPTH (mtac_pkg::WORDS)
    ) u_state_ram (
        .clk       (clk),
        .wr_en     (s1_move),
        .wr_addr   (s1_idx_reg),
        .wr_data   (twisted),
        .rd_en     (accept),
        .rd_addr_a (addr_near),
        .rd_addr_b (addr_far),
        .rd_data_a (ram_near),
        .rd_data_b (ram_far)
    );

    mtac_start_rom u_start_rom (
        .clk    (clk),
        .rd_en  (accept),
        .addr_a (addr_near),
        .addr_b (addr_far),
        .data_a (rom_near),
        .data_b (rom_far)
    );

    // Twist one word and derive the keystream byte.
    always_comb
    begin
        near_word = s1_near_ram_reg ? ram_near : rom_near;
        far_word  = s1_far_ram_reg ? ram_far : rom_far;
        upper_bit = s1_fresh_reg ? mtac_pkg::START_ROM[0][31] : upper_reg;
        y_word    = {upper_bit, near_word[30:0]};
        twisted   = far_word ^ (y_word >> 1) ^ (y_word[0] ? mtac_pkg::TWIST_CONST : '0);
        tempered  = mtac_pkg::temper(twisted);
        key_byte  = tempered[7:0];
        result_byte = s1_item_reg.mode ? (s1_item_reg.data_in - key_byte)
                                       : (s1_item_reg.data_in + key_byte);
    end

    always_comb
    begin
        index_next     = index_reg;
        fill_next      = fill_reg;
        s1_valid_next  = s1_valid_reg;
        dst_valid_next = dst_valid_reg;
        if (accept)
        begin
            index_next    = addr_near;
            fill_next     = (cur_fill == mtac_pkg::FULL_FILL) ? cur_fill : cur_fill + 1'b1;
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            dst_valid_next = 1'b1;
        end
        else if (dst_valid_reg && !dst_stall)
        begin
            dst_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg     <= index_next;
            fill_reg      <= fill_next;
            s1_valid_reg  <= s1_valid_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg      <= cur_idx;
            s1_item_reg     <= src_item;
            s1_near_ram_reg <= (addr_near < cur_fill);
            s1_far_ram_reg  <= (addr_far < cur_fill);
            s1_fresh_reg    <= (cur_fill == '0);
        end
        if (s1_move)
        begin
            // Hold the neighbor's top bit: it is the next byte's own word.
            upper_reg             <= near_word[31];
            dst_item_reg.data_out <= result_byte;
            dst_item_reg.last_out <= s1_item_reg.last_of_message;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

    `ASSERT_ALWAYS(a_index_range, index_reg <= mtac_pkg::LAST_IDX, "word index out of range")
    `ASSERT_ALWAYS(a_fill_track, fill_reg == index_reg || fill_reg == mtac_pkg::FULL_FILL, "fill off")
    `ASSERT_IMPLY(a_accept_stage, accept, s1_valid_reg, "accepted item missing from twist stage")

endmodule
